@@ rtl/bitmap_slot_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator
// Clocked property checks; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every edge outside reset
`define BSA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("slot allocator check failed");
// consequence that must hold in the cycle after the antecedent
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot allocator sequence check failed");
`else
`define BSA_ASSERT(lbl, expr)
`define BSA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot allocator package
// Sizes, codes, controller/datapath structs and the bit scan functions.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SLOTS        = 1024;
  localparam int WORD_BITS    = 64;
  localparam int NWORDS       = SLOTS / WORD_BITS;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int BIT_IDX_W    = $clog2(WORD_BITS);
  localparam int WORD_IDX_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int COUNT_W      = $clog2(SLOTS + 1);
  localparam int SLOT_BYTES_W = 16;
  localparam int WIU_W        = 5;
  localparam int OFFSET_W     = 26;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_DATA_W    = ((SLOT_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + OFFSET_W + 2 * COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_BYTES   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WORDS_IN_USE = CFG_INDEX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    grant_wm;
    logic    scan_lo_word;
    logic    grant_lo;
    logic    free_slot;
    logic    scan_hi_word;
    logic    set_hi_mark;
    logic    clear_pool;
    logic    load_result;
    status_t res_status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic wm_below_cap;
    logic any_free;
    logic idx_in_range;
    logic idx_bit_set;
    logic idx_is_top;
    logic out_free;
  } stat_t;

  // capacity in slots; zero words acts as one, too many as the full pool
  function automatic logic [COUNT_W-1:0] cap_of(input logic [WIU_W-1:0] wiu);
    logic [WIU_W-1:0] w;
    w = wiu;
    if (w == '0) w = WIU_W'(1);
    if (w > WIU_W'(NWORDS)) w = WIU_W'(NWORDS);
    return COUNT_W'(w) << BIT_IDX_W;
  endfunction

  // index of the lowest set bit (isolate it, then encode the one-hot)
  function automatic logic [BIT_IDX_W-1:0] low_one_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] iso;
    logic [BIT_IDX_W-1:0] r;
    iso = v & (~v + WORD_BITS'(1));
    r   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) r = r | BIT_IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] high_one_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] rev;
    for (int i = 0; i < WORD_BITS; i++) begin
      rev[i] = v[WORD_BITS-1-i];
    end
    return BIT_IDX_W'(WORD_BITS - 1) - low_one_word(rev);
  endfunction

  function automatic logic [WORD_IDX_W-1:0] low_one_flags(input logic [NWORDS-1:0] v);
    logic [NWORDS-1:0]     iso;
    logic [WORD_IDX_W-1:0] r;
    iso = v & (~v + NWORDS'(1));
    r   = '0;
    for (int i = 0; i < NWORDS; i++) begin
      if (iso[i]) r = r | WORD_IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [WORD_IDX_W-1:0] high_one_flags(input logic [NWORDS-1:0] v);
    logic [NWORDS-1:0] rev;
    for (int i = 0; i < NWORDS; i++) begin
      rev[i] = v[NWORDS-1-i];
    end
    return WORD_IDX_W'(NWORDS - 1) - low_one_flags(rev);
  endfunction

endpackage

@@ rtl/bsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences one command at a time through the datapath and picks the status.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_top_defines.svh"

module bsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  bsa_pkg::stat_t stat,
  output bsa_pkg::ctl_t  ctl
);
  import bsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LO_WORD,
    S_LO_BIT,
    S_HI_WORD,
    S_HI_BIT,
    S_RESULT
  } state_t;

  state_t  state, state_next;
  status_t res_status, res_status_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    ctl             = '0;
    ctl.res_status  = res_status;
    state_next      = state;
    res_status_next = res_status;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.load_item   = 1'b1;
          res_status_next = ST_OK;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESULT;
        unique case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.wm_below_cap) begin
              ctl.grant_wm = 1'b1;
            end else if (stat.any_free) begin
              state_next = S_LO_WORD;
            end else begin
              res_status_next = ST_FULL;
            end
          end
          CMD_FREE: begin
            if (!stat.idx_in_range) begin
              res_status_next = ST_INVALID;
            end else if (!stat.idx_bit_set) begin
              res_status_next = ST_DOUBLE;
            end else begin
              ctl.free_slot = 1'b1;
              if (stat.idx_is_top) state_next = S_HI_WORD;
            end
          end
          CMD_CLEAR: begin
            ctl.clear_pool = 1'b1;
          end
          CMD_BAD: begin
            res_status_next = ST_INVALID;
          end
        endcase
      end
      S_LO_WORD: begin
        ctl.scan_lo_word = 1'b1;
        state_next       = S_LO_BIT;
      end
      S_LO_BIT: begin
        ctl.grant_lo = 1'b1;
        state_next   = S_RESULT;
      end
      S_HI_WORD: begin
        ctl.scan_hi_word = 1'b1;
        state_next       = S_HI_BIT;
      end
      S_HI_BIT: begin
        ctl.set_hi_mark = 1'b1;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          ctl.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  `BSA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `BSA_ASSERT(a_lo_scan_has_free, (state != S_LO_BIT) || stat.any_free)
  `BSA_ASSERT(a_result_only_free, !ctl.load_result || stat.out_free)

endmodule

@@ rtl/bsa_datapath.sv @@
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Occupancy words, water mark, free count, config registers, result stage.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_top_defines.svh"

module bsa_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [bsa_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [bsa_pkg::CMD_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bsa_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [bsa_pkg::STATUS_W-1:0]     m_tuser,
  input  bsa_pkg::ctl_t                    ctl,
  output bsa_pkg::stat_t                   stat
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0]    words [NWORDS];
  logic [NWORDS-1:0]       word_full;
  logic [NWORDS-1:0]       word_used;
  logic [COUNT_W-1:0]      water_mark;
  logic [COUNT_W-1:0]      free_count;
  logic [SLOT_BYTES_W-1:0] slot_bytes;
  logic [WIU_W-1:0]        words_in_use;
  logic [COUNT_W-1:0]      cap_slots;

  cmd_t                    cmd_r;
  logic [SLOT_W-1:0]       idx_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [WORD_IDX_W-1:0]   lo_word;
  logic [WORD_IDX_W-1:0]   hi_word;
  logic                    hi_any;

  logic [STATUS_W-1:0]     out_status;
  logic [SLOT_W-1:0]       out_given;
  logic [OFFSET_W-1:0]     out_offset;
  logic [COUNT_W-1:0]      out_free;
  logic [COUNT_W-1:0]      out_high;

  logic [WORD_IDX_W-1:0]   idx_word;
  logic [BIT_IDX_W-1:0]    idx_bit;
  logic [WORD_IDX_W-1:0]   wm_word;
  logic [BIT_IDX_W-1:0]    wm_bit;
  logic [BIT_IDX_W-1:0]    lo_bit;
  logic [BIT_IDX_W-1:0]    hi_bit;
  logic [OFFSET_W-1:0]     product;
  logic                    cfg_words_wr;

  assign cfg_ready    = 1'b1;
  assign cap_slots    = cap_of(words_in_use);
  assign cfg_words_wr = cfg_valid && (cfg_index == REG_WORDS_IN_USE);

  assign idx_word = WORD_IDX_W'(idx_r >> BIT_IDX_W);
  assign idx_bit  = idx_r[BIT_IDX_W-1:0];
  assign wm_word  = WORD_IDX_W'(water_mark >> BIT_IDX_W);
  assign wm_bit   = water_mark[BIT_IDX_W-1:0];
  assign lo_bit   = low_one_word(~words[lo_word]);
  assign hi_bit   = high_one_word(words[hi_word]);
  assign product  = OFFSET_W'(slot_r) * OFFSET_W'(slot_bytes);

  always_comb begin
    for (int w = 0; w < NWORDS; w++) begin
      word_full[w] = &words[w];
      word_used[w] = |words[w];
    end
  end

  always_comb begin
    stat.cmd          = cmd_r;
    stat.wm_below_cap = water_mark < cap_slots;
    stat.any_free     = free_count != '0;
    stat.idx_in_range = COUNT_W'(idx_r) < cap_slots;
    stat.idx_bit_set  = words[idx_word][idx_bit];
    stat.idx_is_top   = (COUNT_W'(idx_r) + COUNT_W'(1)) == water_mark;
    stat.out_free     = !m_tvalid || m_tready;
  end

  // pool state and handshake flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bytes   <= SLOT_BYTES_W'(1);
      words_in_use <= WIU_W'(NWORDS);
      for (int w = 0; w < NWORDS; w++) words[w] <= '0;
      water_mark   <= '0;
      free_count   <= cap_of(WIU_W'(NWORDS));
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == REG_SLOT_BYTES)) begin
        slot_bytes <= cfg_data[SLOT_BYTES_W-1:0];
      end
      // a capacity change empties the pool
      if (cfg_words_wr) begin
        words_in_use <= cfg_data[WIU_W-1:0];
        for (int w = 0; w < NWORDS; w++) words[w] <= '0;
        water_mark   <= '0;
        free_count   <= cap_of(cfg_data[WIU_W-1:0]);
      end
      if (ctl.grant_wm) begin
        words[wm_word][wm_bit] <= 1'b1;
        water_mark             <= water_mark + COUNT_W'(1);
        free_count             <= free_count - COUNT_W'(1);
      end
      if (ctl.grant_lo) begin
        words[lo_word][lo_bit] <= 1'b1;
        free_count             <= free_count - COUNT_W'(1);
      end
      if (ctl.free_slot) begin
        words[idx_word][idx_bit] <= 1'b0;
        free_count               <= free_count + COUNT_W'(1);
      end
      // top slot freed: mark drops to one past the highest slot still held
      if (ctl.set_hi_mark) begin
        water_mark <= hi_any ? (COUNT_W'({hi_word, hi_bit}) + COUNT_W'(1)) : '0;
      end
      if (ctl.clear_pool) begin
        for (int w = 0; w < NWORDS; w++) words[w] <= '0;
        water_mark <= '0;
        free_count <= cap_slots;
      end
      if (ctl.load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item, scan and result payload
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r  <= cmd_t'(s_tuser);
      idx_r  <= s_tdata[SLOT_W-1:0];
      slot_r <= '0;
    end
    if (ctl.grant_wm) slot_r <= water_mark[SLOT_W-1:0];
    if (ctl.grant_lo) slot_r <= SLOT_W'({lo_word, lo_bit});
    if (ctl.scan_lo_word) lo_word <= low_one_flags(~word_full);
    if (ctl.scan_hi_word) begin
      hi_word <= high_one_flags(word_used);
      hi_any  <= |word_used;
    end
    if (ctl.load_result) begin
      out_status <= ctl.res_status;
      out_given  <= slot_r;
      out_offset <= product;
      out_free   <= free_count;
      out_high   <= water_mark;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_high, out_free, out_offset, out_given};

  `BSA_ASSERT(a_free_le_cap, free_count <= cap_slots)
  `BSA_ASSERT(a_mark_le_cap, water_mark <= cap_slots)
  `BSA_ASSERT(a_free_above_mark, (cap_slots - water_mark) <= free_count)

endmodule

@@ rtl/bitmap_slot_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Fixed-size slot pool with occupancy bitmap, high-water mark and free count.
// ----------------------------------------------------------------------------
// One command is handled at a time. Allocate from the high-water mark,
// allocate into a full pool, free, clear and rejected commands go from the
// execute state to the result state. An allocate that has to fall back to
// the lowest free slot and a free of the top slot pass through a word-scan
// and a bit-scan state: the controller scans the per-word full/used flags
// for a word, then that 64-bit word for the bit, one registered step each.
// A new command is taken as soon as the result sits in the output register,
// which holds it until the master side takes the transfer. Configuration
// writes are always ready; a write to words_in_use empties the pool.
module bitmap_slot_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  // command stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bsa_pkg::IN_DATA_W-1:0]    s_tdata,  // slot_index
  input  logic [bsa_pkg::CMD_W-1:0]        s_tuser,  // command
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // given_slot, byte_offset, free_slots, high_water
  output logic [bsa_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [bsa_pkg::STATUS_W-1:0]     m_tuser   // status
);
  import bsa_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  bsa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
